FILE: hdl/mbc_pkg.sv
// Package for the multigame bank controller: codes, constants, state and result types, mux tables.
package mbc_pkg;

  // Bus request kinds seen on the snoop channel
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SELECT = 2'd2,
    OP_NONE   = 2'd3
  } mbc_op_e;

  // Decoded register addresses
  localparam logic [15:0] ADDR_PAGE  = 16'hD000;
  localparam logic [15:0] ADDR_GAME  = 16'hC400;
  localparam logic [15:0] ADDR_SOUND = 16'hC401;
  localparam logic [15:0] ADDR_START = 16'hC804;
  localparam logic [3:0]  WIN_HI     = 4'hC;     // C000-CFFF window
  localparam logic [7:0]  VIDEO_HI   = 8'hC9;    // C900-C9FF video/cocktail latch
  localparam logic [5:0]  NVRAM_HI   = 6'b110011; // CC00-CFFF NVRAM window

  localparam logic [7:0]  START_MASK  = 8'h30;   // both start buttons
  localparam logic [2:0]  GAME_MENU   = 3'd0;
  localparam logic [2:0]  GAME_PAGED  = 3'd5;    // game with ROM pages in the window
  localparam logic [3:0]  PAGE_IO     = 4'd0;
  localparam logic [3:0]  PAGE_LAST   = 4'd3;    // pages 1..3 map straight through
  localparam logic [3:0]  PAGE_WIDE   = 4'd7;    // page 7 maps to window 4
  localparam logic [2:0]  WINDOW_IO   = 3'd0;
  localparam logic [2:0]  WINDOW_WIDE = 3'd4;

  // Bank state
  typedef struct packed {
    logic [2:0] game;
    logic [3:0] page;
    logic [2:0] window;
    logic       video_rom;
    logic [3:0] port_sel;
    logic       cocktail;
  } mbc_state_t;

  // One result
  typedef struct packed {
    logic [3:0]  main_bank_entry;
    logic [2:0]  program_bank;
    logic [2:0]  io_page;
    logic        nvram_hit;
    logic [12:0] nvram_address;
    logic [4:0]  port_a_index;
    logic [4:0]  port_b_index;
    logic        sound_reset;
    logic        cpu_reset;
    logic        cocktail;
  } mbc_result_t;

  // Input bank routed to player port A
  function automatic logic [4:0] mux_a(input logic [3:0] sel);
    logic [4:0] r;
    case (sel)
      4'd0, 4'd1:   r = 5'd0;
      4'd2, 4'd3:   r = 5'd2;
      4'd4:         r = 5'd5;
      4'd5:         r = 5'd4;
      4'd6, 4'd7:   r = 5'd7;
      4'd8, 4'd9:   r = 5'd9;
      4'd10, 4'd11: r = 5'd11;
      4'd12:        r = 5'd14;
      4'd13:        r = 5'd13;
      default:      r = 5'd9;
    endcase
    return r;
  endfunction

  // Input bank routed to player port B
  function automatic logic [4:0] mux_b(input logic [3:0] sel);
    logic [4:0] r;
    case (sel)
      4'd0, 4'd1:   r = 5'd1;
      4'd2, 4'd3:   r = 5'd3;
      4'd4, 4'd5:   r = 5'd6;
      4'd6, 4'd7:   r = 5'd8;
      4'd8, 4'd9:   r = 5'd10;
      4'd10, 4'd11: r = 5'd12;
      4'd12:        r = 5'd16;
      4'd13:        r = 5'd15;
      default:      r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/multigame_bank_controller_core.sv
// Top level of the multigame bank controller: bank state and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | operation, address, bus_data, select_line
//  out     | output    | out_valid_o / out_stall_i | bank, page, NVRAM decode, mux, pulses
//
// One request per cycle while in_stall_o is low; its result appears in the cycle after acceptance, from the
// single result register fed by the decode logic.
// Reset clears the bank state to the menu with the I/O window and clears the output valid flag.
// While out_stall_i holds a waiting result, in_stall_o is raised and the result holds.
module multigame_bank_controller_core import mbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  bus_data_i,
  input  logic        select_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  main_bank_entry_o,
  output logic [2:0]  program_bank_o,
  output logic [2:0]  io_page_o,
  output logic        nvram_hit_o,
  output logic [12:0] nvram_address_o,
  output logic [4:0]  port_a_index_o,
  output logic [4:0]  port_b_index_o,
  output logic        sound_reset_o,
  output logic        cpu_reset_o,
  output logic        cocktail_o
);

  mbc_state_t  state_q, state_d;
  mbc_result_t result_q, result_d;
  logic        out_valid_q;
  logic        accept;

  // Stall only while a result waits and is held back
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  mbc_step u_step (
    .state_i       (state_q),
    .operation_i   (operation_i),
    .address_i     (address_i),
    .bus_data_i    (bus_data_i),
    .select_line_i (select_line_i),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  // Bank state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign main_bank_entry_o = result_q.main_bank_entry;
  assign program_bank_o    = result_q.program_bank;
  assign io_page_o         = result_q.io_page;
  assign nvram_hit_o       = result_q.nvram_hit;
  assign nvram_address_o   = result_q.nvram_address;
  assign port_a_index_o    = result_q.port_a_index;
  assign port_b_index_o    = result_q.port_b_index;
  assign sound_reset_o     = result_q.sound_reset;
  assign cpu_reset_o       = result_q.cpu_reset;
  assign cocktail_o        = result_q.cocktail;

endmodule

FILE: hdl/mbc_step.sv
// Next-state and result logic for one snooped bus request.
module mbc_step import mbc_pkg::*; (
  input  mbc_state_t  state_i,
  input  logic [1:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  bus_data_i,
  input  logic        select_line_i,
  output mbc_state_t  state_o,
  output mbc_result_t result_o
);

  mbc_op_e    op;
  logic       io_window;
  logic       hit;
  logic       game_req;
  logic [2:0] game_val;
  logic       sound_pulse;
  logic       cpu_pulse;
  logic [3:0] page_val;
  mbc_state_t nxt;

  assign op        = mbc_op_e'(operation_i);
  assign io_window = (state_i.window == WINDOW_IO) && (address_i[15:12] == WIN_HI);
  assign hit       = ((op == OP_WRITE) || (op == OP_READ)) && io_window &&
                     (address_i[15:10] == NVRAM_HI);
  assign page_val  = bus_data_i[3:0];

  // Decode the request
  always_comb begin
    nxt         = state_i;
    game_req    = 1'b0;
    game_val    = bus_data_i[2:0];
    sound_pulse = 1'b0;
    cpu_pulse   = 1'b0;
    case (op)
      OP_WRITE: begin
        if (address_i == ADDR_PAGE) begin
          if (page_val != state_i.page) begin
            if (state_i.game == GAME_PAGED && page_val != PAGE_IO) begin
              if (page_val <= PAGE_LAST) begin
                nxt.window = page_val[2:0];
              end else if (page_val == PAGE_WIDE) begin
                nxt.window = WINDOW_WIDE;
              end
            end else if (page_val == PAGE_IO) begin
              nxt.window = WINDOW_IO;
            end
            nxt.page = page_val;
          end
        end else if (io_window) begin
          if (address_i == ADDR_GAME) begin
            game_req = 1'b1;
          end else if (address_i == ADDR_SOUND) begin
            sound_pulse = ~bus_data_i[0];
          end else if (address_i[15:8] == VIDEO_HI) begin
            nxt.video_rom = bus_data_i[0];
            nxt.cocktail  = bus_data_i[1];
          end
        end
      end
      OP_READ: begin
        // both start buttons during a game: back to the menu
        if (io_window && address_i == ADDR_START && state_i.game != GAME_MENU &&
            (bus_data_i & START_MASK) == START_MASK) begin
          game_req  = 1'b1;
          game_val  = GAME_MENU;
          cpu_pulse = 1'b1;
        end
      end
      OP_SELECT: begin
        nxt.port_sel = {state_i.game, select_line_i};
      end
      default: begin
      end
    endcase

    // Game select: only to or from the menu
    if (game_req && game_val != state_i.game &&
        (game_val == GAME_MENU || state_i.game == GAME_MENU)) begin
      nxt.game    = game_val;
      nxt.page    = PAGE_IO;
      nxt.window  = WINDOW_IO;
      sound_pulse = 1'b1;
    end
  end

  // Result from the updated state
  always_comb begin
    result_o.main_bank_entry = nxt.video_rom ? ({1'b0, nxt.game} + 4'd1) : 4'd0;
    result_o.program_bank    = nxt.game;
    result_o.io_page         = nxt.window;
    result_o.nvram_hit       = hit;
    result_o.nvram_address   = hit ? {state_i.game, address_i[9:0]} : 13'd0;
    result_o.port_a_index    = mux_a(nxt.port_sel);
    result_o.port_b_index    = mux_b(nxt.port_sel);
    result_o.sound_reset     = sound_pulse;
    result_o.cpu_reset       = cpu_pulse;
    result_o.cocktail        = nxt.cocktail;
  end

  assign state_o = nxt;

endmodule

FILE: hdl/mbc_checker.sv
// Port checker for the multigame bank controller, bound to the top level.
module mbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  main_bank_entry_o,
  input logic [2:0]  program_bank_o,
  input logic [2:0]  io_page_o,
  input logic        nvram_hit_o,
  input logic [12:0] nvram_address_o,
  input logic        sound_reset_o,
  input logic        cpu_reset_o
);

  // Forced menu also resets sound
  a_cpu_sound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cpu_reset_o) |-> sound_reset_o)
    else $error("cpu reset without sound reset");

  // Forced menu lands on game 0 with the I/O window
  a_cpu_menu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cpu_reset_o) |-> (program_bank_o == 3'd0 && io_page_o == 3'd0))
    else $error("cpu reset did not return to menu");

  // NVRAM slice follows the current game, only with the I/O window
  a_nvram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && nvram_hit_o) |->
      (nvram_address_o[12:10] == program_bank_o && io_page_o == 3'd0))
    else $error("NVRAM decode inconsistent with bank state");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(main_bank_entry_o) && $stable(nvram_address_o)))
    else $error("stalled result changed");

endmodule

bind multigame_bank_controller_core mbc_checker u_mbc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .main_bank_entry_o (main_bank_entry_o),
  .program_bank_o    (program_bank_o),
  .io_page_o         (io_page_o),
  .nvram_hit_o       (nvram_hit_o),
  .nvram_address_o   (nvram_address_o),
  .sound_reset_o     (sound_reset_o),
  .cpu_reset_o       (cpu_reset_o)
);
